FILE: rtl/wkep_pkg.sv
// shared constants, operation codes and field widths of the weighted keyed entry picker
package wkep_pkg;

   // table depth default
   localparam int ENTRIES_DEF = 1024;

   // field widths
   localparam int KEY_W    = 64;
   localparam int COORD_W  = 3;
   localparam int PROMO_W  = 8;
   localparam int WEIGHT_W = 16;
   localparam int RAND_W   = 31;
   localparam int MOVE_W   = 4 * COORD_W + PROMO_W;
   localparam int BIT_W    = $clog2(RAND_W);

   // operation codes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

endpackage

FILE: rtl/weighted_keyed_entry_picker_core.sv
// weighted keyed entry picker: keyed move table with roulette-wheel lookup
//
// A clear or insert transaction passes through the done state, which loads its result
// into the output register once that register is free; the next transaction is taken
// after the done state. A lookup on a loaded table scans the stored entries once to sum
// the weights of matching keys. If that sum is positive, it then reduces random_value
// modulo that sum one bit per cycle and scans the entries again up to the picked one.
// It reads the picked move and hands it to the output register through the done state.
// The lookup time is set by the single-port entry memory, read one entry a cycle, and
// by the one shared adder that does the summing, the division steps and the walk. The
// block takes one transaction at a time; the result register lets a finished result
// wait on rsp_stall while the core goes idle.
// The entry memory has no reset and needs no clearing pass: only entries below the
// fill count are ever read.
module weighted_keyed_entry_picker_core
   import wkep_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_operation,
   input  logic [KEY_W-1:0]           req_key,
   input  logic [COORD_W-1:0]         req_from_row,
   input  logic [COORD_W-1:0]         req_from_col,
   input  logic [COORD_W-1:0]         req_to_row,
   input  logic [COORD_W-1:0]         req_to_col,
   input  logic [PROMO_W-1:0]         req_promotion,
   input  logic signed [WEIGHT_W-1:0] req_weight,
   input  logic [RAND_W-1:0]          req_random_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic [COORD_W-1:0]         rsp_out_from_row,
   output logic [COORD_W-1:0]         rsp_out_from_col,
   output logic [COORD_W-1:0]         rsp_out_to_row,
   output logic [COORD_W-1:0]         rsp_out_to_col,
   output logic [PROMO_W-1:0]         rsp_out_promotion,
   output logic                       rsp_is_loaded,
   output logic                       rsp_table_full
);

   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SUM_W  = WEIGHT_W + CNT_W;
   localparam int PICK_W = SUM_W + 1;
   localparam int ALU_W  = SUM_W + 2;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_MOVE  = 3'd4;
   localparam logic [2:0] ST_MOVE2 = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // entry memories
   logic [KEY_W-1:0]           keys_mem    [ENTRIES];
   logic [MOVE_W-1:0]          moves_mem   [ENTRIES];
   logic signed [WEIGHT_W-1:0] weights_mem [ENTRIES];

   // control state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic             loaded_ff, loaded_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [KEY_W-1:0]           key_ff, key_in;
   logic [RAND_W-1:0]          rand_ff, rand_in;
   logic [CNT_W-1:0]           addr_ff, addr_in;
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]           last_ff, last_in;
   logic [IDX_W-1:0]           chosen_ff, chosen_in;
   logic                       any_ff, any_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]           rem_ff, rem_in;
   logic signed [PICK_W-1:0]   pick_ff, pick_in;
   logic [BIT_W-1:0]           bit_ff, bit_in;
   logic                       res_found_ff, res_found_in;
   logic                       res_full_ff, res_full_in;
   logic [MOVE_W-1:0]          res_move_ff, res_move_in;

   // memory read data
   logic [KEY_W-1:0]           key_rd_ff;
   logic [MOVE_W-1:0]          move_rd_ff;
   logic signed [WEIGHT_W-1:0] weight_rd_ff;

   // output register
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              rsp_loaded_ff, rsp_loaded_in;
   logic [MOVE_W-1:0] rsp_move_ff, rsp_move_in;

   // misc
   logic              accept;
   logic              out_free;
   logic              scan_active;
   logic              issue;
   logic              scan_end;
   logic              hit;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [SUM_W:0]    div_tmp;
   logic signed [ALU_W-1:0] alu_a, alu_b, alu_sum;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // scan control
   assign scan_active = (state_ff == ST_SUM) || (state_ff == ST_WALK);
   assign issue       = scan_active && (addr_ff < entry_count_ff);
   assign scan_end    = scan_active && !issue && !rd_valid_ff;
   assign hit         = rd_valid_ff && (key_rd_ff == key_ff);
   assign rd_addr     = (state_ff == ST_MOVE) ? chosen_ff : addr_ff[IDX_W-1:0];
   assign wr_en       = accept && (req_operation == OP_INSERT)
                        && (entry_count_ff < CNT_W'(ENTRIES));

   // restoring division trial value
   assign div_tmp = {rem_ff, rand_ff[bit_ff]};

   // shared adder: weight sum, division trial subtract, walk subtract
   always_comb begin
      unique case (state_ff)
         ST_SUM: begin
            alu_a = ALU_W'(sum_ff);
            alu_b = ALU_W'(weight_rd_ff);
         end
         ST_DIV: begin
            alu_a = signed'(ALU_W'(div_tmp));
            alu_b = -ALU_W'(sum_ff);
         end
         ST_WALK: begin
            alu_a = ALU_W'(pick_ff);
            alu_b = -ALU_W'(weight_rd_ff);
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end
   assign alu_sum = alu_a + alu_b;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      loaded_in      = loaded_ff;
      rd_valid_in    = issue;
      key_in         = key_ff;
      rand_in        = rand_ff;
      addr_in        = issue ? CNT_W'(addr_ff + 1'b1) : addr_ff;
      rd_idx_in      = addr_ff[IDX_W-1:0];
      last_in        = last_ff;
      chosen_in      = chosen_ff;
      any_in         = any_ff;
      sum_in         = sum_ff;
      rem_in         = rem_ff;
      pick_in        = pick_ff;
      bit_in         = bit_ff;
      res_found_in   = res_found_ff;
      res_full_in    = res_full_ff;
      res_move_in    = res_move_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in       = req_key;
               rand_in      = req_random_value;
               res_found_in = 1'b0;
               res_full_in  = 1'b0;
               res_move_in  = '0;
               addr_in      = '0;
               any_in       = 1'b0;
               sum_in       = '0;
               last_in      = '0;
               state_in     = ST_DONE;
               case (req_operation)
                  OP_CLEAR: begin
                     entry_count_in = '0;
                     loaded_in      = 1'b1;
                  end
                  OP_INSERT: begin
                     if (wr_en) begin
                        entry_count_in = CNT_W'(entry_count_ff + 1'b1);
                     end else begin
                        res_full_in = 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     if (loaded_ff) begin
                        state_in = ST_SUM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SUM: begin
            if (hit) begin
               sum_in  = alu_sum[SUM_W-1:0];
               any_in  = 1'b1;
               last_in = rd_idx_ff;
            end
            if (scan_end) begin
               if (any_ff && !sum_ff[SUM_W-1] && (sum_ff != '0)) begin
                  rem_in   = '0;
                  bit_in   = BIT_W'(RAND_W - 1);
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            if (!alu_sum[ALU_W-1]) begin
               rem_in = alu_sum[SUM_W-1:0];
            end else begin
               rem_in = div_tmp[SUM_W-1:0];
            end
            bit_in = BIT_W'(bit_ff - 1'b1);
            if (bit_ff == '0) begin
               pick_in   = signed'({1'b0, rem_in});
               chosen_in = last_ff;
               addr_in   = '0;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (hit) begin
               pick_in = alu_sum[PICK_W-1:0];
               if (alu_sum[ALU_W-1]) begin
                  chosen_in = rd_idx_ff;
                  state_in  = ST_MOVE;
               end
            end
            if (scan_end) begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            state_in = ST_MOVE2;
         end
         ST_MOVE2: begin
            res_found_in = 1'b1;
            res_move_in  = move_rd_ff;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register load
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_loaded_in = rsp_loaded_ff;
      rsp_move_in   = rsp_move_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = res_found_ff;
         rsp_full_in   = res_full_ff;
         rsp_loaded_in = loaded_ff;
         rsp_move_in   = res_move_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         loaded_ff      <= 1'b0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         loaded_ff      <= loaded_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      rand_ff       <= rand_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      last_ff       <= last_in;
      chosen_ff     <= chosen_in;
      any_ff        <= any_in;
      sum_ff        <= sum_in;
      rem_ff        <= rem_in;
      pick_ff       <= pick_in;
      bit_ff        <= bit_in;
      res_found_ff  <= res_found_in;
      res_full_ff   <= res_full_in;
      res_move_ff   <= res_move_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_loaded_ff <= rsp_loaded_in;
      rsp_move_ff   <= rsp_move_in;
   end

   // entry memory write on insert
   always_ff @(posedge clock) begin
      if (wr_en) begin
         keys_mem[entry_count_ff[IDX_W-1:0]]    <= req_key;
         moves_mem[entry_count_ff[IDX_W-1:0]]   <= {req_from_row, req_from_col, req_to_row,
                                                    req_to_col, req_promotion};
         weights_mem[entry_count_ff[IDX_W-1:0]] <= req_weight;
      end
   end

   // entry memory registered read
   always_ff @(posedge clock) begin
      key_rd_ff    <= keys_mem[rd_addr];
      move_rd_ff   <= moves_mem[rd_addr];
      weight_rd_ff <= weights_mem[rd_addr];
   end

   // result ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_out_from_row  = rsp_move_ff[MOVE_W-1 -: COORD_W];
   assign rsp_out_from_col  = rsp_move_ff[MOVE_W-1-COORD_W -: COORD_W];
   assign rsp_out_to_row    = rsp_move_ff[MOVE_W-1-2*COORD_W -: COORD_W];
   assign rsp_out_to_col    = rsp_move_ff[MOVE_W-1-3*COORD_W -: COORD_W];
   assign rsp_out_promotion = rsp_move_ff[PROMO_W-1:0];
   assign rsp_is_loaded     = rsp_loaded_ff;
   assign rsp_table_full    = rsp_full_ff;

   // fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(ENTRIES))
      else $error("entry count beyond table depth");

   // a pick only comes from a loaded table
   a_found_loaded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_is_loaded)
      else $error("hit reported on an unloaded table");

   // a dropped insert never reports a pick
   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_table_full))
      else $error("full and found together");

   // the block is busy right after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken back to back");

endmodule
